// ===== rtl/spd_pkg.sv =====
// shared types and constants of the serial packet deframer
package spd_pkg;

  localparam logic [7:0] MARK_BYTE = 8'h01;
  localparam logic [7:0] CHAR_BIAS = 8'd32;
  localparam logic [7:0] SEQ_LIMIT = 8'd63;
  localparam logic [7:0] HIGH_BITS = 8'd192;
  localparam logic [7:0] LEN_BIAS  = 8'd30;
  localparam logic [6:0] MIN_LEN   = 7'd5;
  localparam logic [6:0] LEN_RESET = 7'd64;

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_BAD_SEQ = 3'd3;
  localparam logic [2:0] ST_BAD_SUM = 3'd4;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic [2:0] emit_code;
    logic       fail_inc;
    logic       drain_start;
    logic       rd;
    logic       load_data;
  } spd_cmd_t;

  typedef struct packed {
    logic at_len;
    logic at_seq;
    logic at_final;
    logic len_bad;
    logic seq_bad;
    logic sum_ok;
    logic empty;
    logic drain_last;
    logic out_free;
  } spd_stat_t;

endpackage

// ===== rtl/spd_ram.sv =====
// generic single write port ram with registered read
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spd_datapath.sv =====
// deframer datapath: frame counters, checksum, payload buffer and result register
module spd_datapath #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic [7:0]        rx_byte,
  input  spd_pkg::spd_cmd_t cmd,
  output spd_pkg::spd_stat_t st,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);
  import spd_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FRAME_CAP = (BUFFER_DEPTH < 64) ? BUFFER_DEPTH : 64;

  logic [6:0]  max_len;
  logic [5:0]  pos;
  logic [6:0]  len;
  logic [7:0]  sum;
  logic [5:0]  seq;
  logic [7:0]  ptype;
  logic [31:0] fail;
  logic [5:0]  idx;

  logic [2:0]  out_status;
  logic [5:0]  out_seq;
  logic [7:0]  out_type;
  logic [7:0]  out_data;
  logic [5:0]  out_idx;
  logic        out_last;
  logic [31:0] out_bad;

  logic [6:0]  limit;
  logic [5:0]  chk_low;
  logic [7:0]  check;
  logic [31:0] fail_next;
  logic        wr_en;
  logic [7:0]  ram_rdata;
  logic [6:0]  rd_pos;

  assign limit = (max_len < 7'(FRAME_CAP)) ? max_len : 7'(FRAME_CAP);
  assign chk_low = sum[5:0] + {4'b0000, 2'((sum & HIGH_BITS) >> 6)};
  assign check = {2'b00, chk_low} + CHAR_BIAS;

  always_comb begin
    st.at_len     = (pos == 6'd1);
    st.at_seq     = (pos == 6'd2);
    st.at_final   = (pos >= 6'd4) && !(({1'b0, pos} + 7'd1) < len);
    st.len_bad    = (rx_byte < (LEN_BIAS + 8'(MIN_LEN))) ||
                    ((rx_byte - LEN_BIAS) > {1'b0, limit});
    st.seq_bad    = (rx_byte < CHAR_BIAS) || (rx_byte > (CHAR_BIAS + SEQ_LIMIT));
    st.sum_ok     = (check == rx_byte);
    st.empty      = (len == MIN_LEN);
    st.drain_last = (({1'b0, idx} + 7'd1) == (len - MIN_LEN));
    st.out_free   = !m_tvalid || m_tready;
  end

  assign fail_next = (cmd.fail_inc && (fail != '1)) ? fail + 32'd1 : fail;
  assign wr_en = cmd.take && (pos >= 6'd4) && !st.at_final;
  assign rd_pos = 7'd4 + {1'b0, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      len  <= '0;
      sum  <= '0;
      fail <= '0;
    end else begin
      fail <= fail_next;
      if (cmd.take) begin
        priority if (pos == 6'd0) begin
          if (rx_byte == MARK_BYTE) begin
            sum <= '0;
            pos <= 6'd1;
          end
        end else if (st.at_len) begin
          if (st.len_bad) begin
            pos <= '0;
          end else begin
            len <= 7'(rx_byte - LEN_BIAS);
            sum <= rx_byte;
            pos <= 6'd2;
          end
        end else if (st.at_seq) begin
          if (st.seq_bad) begin
            pos <= '0;
          end else begin
            sum <= sum + rx_byte;
            pos <= 6'd3;
          end
        end else if (st.at_final) begin
          pos <= '0;
        end else begin
          sum <= sum + rx_byte;
          pos <= pos + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && st.at_seq) begin
      seq <= 6'(rx_byte - CHAR_BIAS);
    end
    if (cmd.take && (pos == 6'd3)) begin
      ptype <= rx_byte;
    end
    if (cmd.drain_start) begin
      idx <= '0;
    end else if (cmd.load_data) begin
      idx <= idx + 6'd1;
    end
  end

  spd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(pos)),
    .wdata (rx_byte),
    .re    (cmd.rd),
    .raddr (AW'(rd_pos)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit || cmd.load_data) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_code;
      out_data   <= '0;
      out_idx    <= '0;
      out_last   <= 1'b1;
      out_bad    <= fail_next;
      if ((cmd.emit_code == ST_BAD_LEN) || (cmd.emit_code == ST_BAD_SEQ)) begin
        out_seq  <= '0;
        out_type <= '0;
      end else begin
        out_seq  <= seq;
        out_type <= ptype;
      end
    end else if (cmd.load_data) begin
      out_status <= ST_DATA;
      out_seq    <= seq;
      out_type   <= ptype;
      out_data   <= ram_rdata;
      out_idx    <= idx;
      out_last   <= st.drain_last;
      out_bad    <= fail;
    end
  end

  assign m_tdata = {4'b0000, out_bad, out_idx, out_data, out_type, out_seq};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.load_data) |-> st.out_free)
    else $error("result register loaded while occupied");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (fail >= $past(fail)))
    else $error("checksum failure count went down");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_DATA)) |-> m_tlast)
    else $error("status result without tlast");

endmodule

// ===== rtl/spd_ctrl.sv =====
// deframer controller: receive, buffer read and result drain sequencing
module spd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  spd_pkg::spd_stat_t st,
  output spd_pkg::spd_cmd_t  cmd
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    S_RECV = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_RECV) && st.out_free;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.take        = s_tvalid && s_tready;
    cmd.emit_code   = ST_DATA;
    unique case (state)
      S_RECV: begin
        if (cmd.take) begin
          priority if (st.at_len && st.len_bad) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_BAD_LEN;
          end else if (st.at_seq && st.seq_bad) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_BAD_SEQ;
          end else if (st.at_final && !st.sum_ok) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_BAD_SUM;
            cmd.fail_inc  = 1'b1;
          end else if (st.at_final && st.empty) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_EMPTY;
          end else if (st.at_final) begin
            cmd.drain_start = 1'b1;
            state_next      = S_READ;
          end else begin
            cmd.emit = 1'b0;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (st.out_free) begin
          cmd.load_data = 1'b1;
          state_next    = st.drain_last ? S_RECV : S_READ;
        end
      end
      default: state_next = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND && st.out_free && st.drain_last) |=> (state == S_RECV))
    else $error("drain did not return to receive");

  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_start |=> (state == S_READ))
    else $error("drain start did not enter read");

endmodule

// ===== rtl/serial_packet_deframer.sv =====
// top level of the serial packet deframer
//
//  channel   dir  request fields
//  s_*       in   tdata[7:0] rx_byte
//  m_*       out  tuser status; tdata seq, type, data, index, bad sum total; tlast last
//  cfg_*     in   cfg_wr_data max_packet_len, written when cfg_wr_en is high
//
// one received byte is taken per cycle while a packet is being read and the result register is free
// a status result is ready the cycle after its byte; a good packet drains its payload
// bytes one by one (buffer read, then result load), bytes wait meanwhile
// synchronous reset; the payload buffer needs no clearing pass
// a stalled m side holds the result register and blocks further bytes
module serial_packet_deframer #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // seq_number, packet_type, data_byte, data_index, bad_sum_total
  output logic [2:0]  m_tuser,     // status
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data  // max_packet_len
);
  import spd_pkg::*;

  spd_cmd_t  cmd;
  spd_stat_t st;

  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  spd_datapath #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx_byte     (s_tdata),
    .cmd         (cmd),
    .st          (st),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

// ===== tb/tb_serial_packet_deframer.sv =====
// testbench of the serial packet deframer: queued byte driver, deframing predictor, result checker
module tb_serial_packet_deframer;
  import spd_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PCT      = 18;
  localparam int MAX_REPORTS   = 60;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  seq;
    logic [7:0]  ptype;
    logic [7:0]  data;
    logic [5:0]  index;
    logic        last;
    logic [31:0] fails;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = LEN_RESET;

  logic [7:0]    rx_q[$];
  frame_result_t expected_q[$];
  logic          steady = 1'b0;
  int            err_count = 0;
  int            stall_cycles = 0;

  // predictor state
  logic [7:0]  frame_mem[64];
  logic [5:0]  rx_pos = '0;
  logic [6:0]  rx_len = '0;
  logic [7:0]  rx_sum = '0;
  logic [31:0] sum_fails = '0;
  logic [6:0]  len_limit = LEN_RESET;

  serial_packet_deframer #(.BUFFER_DEPTH(64)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] block_check(input logic [7:0] s);
    return ((s + ((s & HIGH_BITS) >> 6)) & SEQ_LIMIT) + CHAR_BIAS;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    int lim;
    int count;
    int i;
    r = '0;
    r.last = 1'b1;
    lim = (int'(len_limit) < 64) ? int'(len_limit) : 64;
    if (rx_pos == 0) begin
      if (b == MARK_BYTE) begin
        frame_mem[0] = b;
        rx_sum = '0;
        rx_pos = 1;
      end
    end else if (rx_pos == 1) begin
      if (int'(b) < int'(LEN_BIAS) + int'(MIN_LEN) || int'(b) - int'(LEN_BIAS) > lim) begin
        rx_pos = 0;
        r.status = ST_BAD_LEN;
        r.fails = sum_fails;
        expected_q.push_back(r);
      end else begin
        frame_mem[1] = b;
        rx_len = 7'(b - LEN_BIAS);
        rx_sum = b;
        rx_pos = 2;
      end
    end else if (rx_pos == 2) begin
      if (b < CHAR_BIAS || b - CHAR_BIAS > SEQ_LIMIT) begin
        rx_pos = 0;
        r.status = ST_BAD_SEQ;
        r.fails = sum_fails;
        expected_q.push_back(r);
      end else begin
        frame_mem[2] = b;
        rx_sum = rx_sum + b;
        rx_pos = 3;
      end
    end else if (rx_pos == 3 || int'(rx_pos) + 1 < int'(rx_len)) begin
      frame_mem[rx_pos] = b;
      rx_sum = rx_sum + b;
      rx_pos = rx_pos + 6'd1;
    end else begin
      rx_pos = 0;
      r.seq = 6'(frame_mem[2] - CHAR_BIAS);
      r.ptype = frame_mem[3];
      if (block_check(rx_sum) != b) begin
        if (sum_fails != 32'hFFFF_FFFF) sum_fails++;
        r.status = ST_BAD_SUM;
        r.fails = sum_fails;
        expected_q.push_back(r);
      end else if (rx_len == MIN_LEN) begin
        r.status = ST_EMPTY;
        r.fails = sum_fails;
        expected_q.push_back(r);
      end else begin
        count = int'(rx_len) - int'(MIN_LEN);
        for (i = 0; i < count; i++) begin
          r.status = ST_DATA;
          r.data = frame_mem[4 + i];
          r.index = 6'(i);
          r.last = (i == count - 1);
          r.fails = sum_fails;
          expected_q.push_back(r);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing pending, status", 32'(m_tuser), 32'h0);
    end else begin
      want = expected_q.pop_front();
      if (m_tuser !== want.status) report_mismatch("status", 32'(m_tuser), 32'(want.status));
      if (m_tdata[5:0] !== want.seq) report_mismatch("seq", 32'(m_tdata[5:0]), 32'(want.seq));
      if (m_tdata[13:6] !== want.ptype)
        report_mismatch("type", 32'(m_tdata[13:6]), 32'(want.ptype));
      if (m_tdata[21:14] !== want.data)
        report_mismatch("data", 32'(m_tdata[21:14]), 32'(want.data));
      if (m_tdata[27:22] !== want.index)
        report_mismatch("index", 32'(m_tdata[27:22]), 32'(want.index));
      if (m_tdata[59:28] !== want.fails)
        report_mismatch("bad sum total", m_tdata[59:28], want.fails);
      if (m_tdata[63:60] !== 4'h0) report_mismatch("padding", 32'(m_tdata[63:60]), 32'h0);
      if (m_tlast !== want.last) report_mismatch("last", 32'(m_tlast), 32'(want.last));
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) deframe_byte(s_tdata);
      if (rx_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata <= rx_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    q = {};
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == MARK_BYTE) v = 8'h00;
    return v;
  endfunction

  task automatic push_frame(input logic [7:0] seq_char, input logic [7:0] ptype,
                            input byte_q_t body, input bit corrupt);
    logic [7:0] len_char;
    logic [7:0] acc;
    logic [7:0] chk;
    len_char = 8'(body.size() + 5) + LEN_BIAS;
    acc = len_char + seq_char + ptype;
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(len_char);
    rx_q.push_back(seq_char);
    rx_q.push_back(ptype);
    foreach (body[i]) begin
      acc = acc + body[i];
      rx_q.push_back(body[i]);
    end
    chk = block_check(acc);
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    rx_q.push_back(chk);
  endtask

  task automatic push_random_traffic(input int nbytes);
    int added;
    int lim;
    int kind;
    int total;
    byte_q_t body;
    added = 0;
    lim = (int'(len_limit) < 64) ? int'(len_limit) : 64;
    while (added < nbytes) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 3)) rx_q.push_back(noise_byte());
      end else if (kind < 80 && lim >= int'(MIN_LEN)) begin
        if ($urandom_range(9) == 0) total = $urandom_range(5, lim);
        else total = $urandom_range(5, (lim < 12) ? lim : 12);
        body = random_body(total - 5);
        push_frame(8'($urandom_range(32, 95)), 8'($urandom), body, kind >= 68);
        added += total;
      end else if (kind < 90 || lim < int'(MIN_LEN)) begin
        rx_q.push_back(MARK_BYTE);
        if ($urandom_range(1)) rx_q.push_back(8'($urandom_range(0, 34)));
        else rx_q.push_back(8'($urandom_range(lim + 31, 255)));
        added += 2;
      end else begin
        rx_q.push_back(MARK_BYTE);
        rx_q.push_back(8'($urandom_range(35, lim + 30)));
        if ($urandom_range(1)) rx_q.push_back(8'($urandom_range(0, 31)));
        else rx_q.push_back(8'($urandom_range(96, 255)));
        added += 3;
      end
    end
  endtask

  task automatic settle();
    while (rx_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    len_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    byte_q_t body;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_limit(LEN_RESET);
    // bytes dropped while hunting
    rx_q.push_back(8'h00);
    rx_q.push_back(8'hFF);
    rx_q.push_back(8'h02);
    body = {};
    push_frame(CHAR_BIAS, 8'h59, body, 1'b0);
    body = {MARK_BYTE, 8'h00, 8'hFF};
    push_frame(8'd95, 8'hFF, body, 1'b0);
    // bad length characters
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd34);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'hFF);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd95);
    // bad sequence characters
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd40);
    rx_q.push_back(8'd31);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd40);
    rx_q.push_back(8'd96);
    body = random_body(3);
    push_frame(8'd33, 8'h44, body, 1'b1);
    body = random_body(1);
    push_frame(8'd50, 8'h00, body, 1'b0);
    settle();

    write_limit(MIN_LEN);
    body = {};
    push_frame(8'd70, 8'h53, body, 1'b0);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd36);
    push_frame(8'd71, 8'h4E, body, 1'b1);
    settle();

    // limit below the minimum length rejects everything
    write_limit(7'd0);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd35);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd34);
    settle();

    write_limit(7'($urandom_range(5, 64)));
    push_random_traffic(6);
    settle();

    // limit above the frame capacity clamps to it
    steady = 1'b1;
    write_limit(7'd127);
    body = random_body(59);
    push_frame(8'd60, MARK_BYTE, body, 1'b0);
    rx_q.push_back(MARK_BYTE);
    rx_q.push_back(8'd95);
    body = {};
    push_frame(8'd90, 8'h5A, body, 1'b0);
    settle();
    steady = 1'b0;

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
